@@ design/tafm_pkg.sv @@
// Package for the throttle arming and flight mode controller.
// Holds the transaction and state types, codes, reset values and code conversions.
// Used by tafm_step and throttle_arming_flight_mode_ctrl_top.
package tafm_pkg;

   localparam logic [15:0] THROTTLE_HIGH_RESET = 16'd900;
   localparam logic [15:0] THROTTLE_LOW_RESET  = 16'd100;
   localparam logic [31:0] HOLD_TICKS_RESET    = 32'd1000;
   localparam logic [7:0]  MISS_LIMIT_RESET    = 8'd10;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THROTTLE_HIGH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_THROTTLE_LOW  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLD_TICKS    = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISS_LIMIT    = 2'd3;

   localparam logic [1:0] LINK_EVENT_GOOD = 2'd1;
   localparam logic [1:0] LINK_EVENT_MISS = 2'd2;

   localparam logic [1:0] FLIGHT_IDLE   = 2'd0;
   localparam logic [1:0] FLIGHT_NORMAL = 2'd1;
   localparam logic [1:0] FLIGHT_HOLD   = 2'd2;
   localparam logic [1:0] FLIGHT_FAILED = 2'd3;

   localparam logic [2:0] ARM_FREE   = 3'd0;
   localparam logic [2:0] ARM_MAX    = 3'd1;
   localparam logic [2:0] ARM_LEFT   = 3'd2;
   localparam logic [2:0] ARM_MIN    = 3'd3;
   localparam logic [2:0] ARM_UNLOCK = 3'd4;

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_NORMAL = 4'b0010,
      MODE_HOLD   = 4'b0100,
      MODE_FAILED = 4'b1000
   } mode_type;

   typedef enum logic [4:0] {
      STAGE_FREE   = 5'b00001,
      STAGE_MAX    = 5'b00010,
      STAGE_LEFT   = 5'b00100,
      STAGE_MIN    = 5'b01000,
      STAGE_UNLOCK = 5'b10000
   } stage_type;

   typedef struct packed {
      logic [1:0]  link_event;
      logic [15:0] throttle;
      logic        height_button;
      logic [31:0] now_ticks;
      logic [15:0] range_mm;
      logic        resume;
   } req_type;

   typedef struct packed {
      logic [1:0]  flight_mode;
      logic [2:0]  arm_stage;
      logic        link_up;
      logic [15:0] held_height;
   } rsp_type;

   typedef struct packed {
      logic [15:0] throttle_high;
      logic [15:0] throttle_low;
      logic [31:0] hold_ticks;
      logic [7:0]  miss_limit;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      stage_type   stage;
      logic [31:0] max_entry_time;
      logic [31:0] min_entry_time;
      logic [7:0]  miss_count;
      logic        link;
      logic [15:0] height;
   } state_type;

   function automatic logic [1:0] mode_code(input mode_type mode);
      logic [1:0] code;
      case (mode)
         MODE_IDLE:   code = FLIGHT_IDLE;
         MODE_NORMAL: code = FLIGHT_NORMAL;
         MODE_HOLD:   code = FLIGHT_HOLD;
         default:     code = FLIGHT_FAILED;
      endcase
      return code;
   endfunction

   function automatic logic [2:0] stage_code(input stage_type stage);
      logic [2:0] code;
      case (stage)
         STAGE_MAX:    code = ARM_MAX;
         STAGE_LEFT:   code = ARM_LEFT;
         STAGE_MIN:    code = ARM_MIN;
         STAGE_UNLOCK: code = ARM_UNLOCK;
         default:      code = ARM_FREE;
      endcase
      return code;
   endfunction

endpackage

@@ design/tafm_step.sv @@
// Next-state logic for one poll transaction: link update, arming sequence and mode changes.
// Purely combinational; depends on tafm_pkg.
module tafm_step (
   input  tafm_pkg::state_type cur,
   input  tafm_pkg::cfg_type   cfg,
   input  tafm_pkg::req_type   item,
   output tafm_pkg::state_type nxt
);

   always_comb begin
      logic [7:0]          miss_inc;
      logic [31:0]         max_span;
      logic [31:0]         min_span;
      tafm_pkg::stage_type arm_stage;
      logic [31:0]         arm_max_time;
      logic [31:0]         arm_min_time;

      nxt = cur;

      miss_inc = cur.miss_count + 8'd1;
      if (item.link_event == tafm_pkg::LINK_EVENT_GOOD) begin
         nxt.link = 1'b1;
         nxt.miss_count = '0;
      end else if (item.link_event == tafm_pkg::LINK_EVENT_MISS) begin
         if (miss_inc >= cfg.miss_limit) begin
            nxt.link = 1'b0;
            nxt.miss_count = '0;
         end else begin
            nxt.miss_count = miss_inc;
         end
      end

      max_span = item.now_ticks - cur.max_entry_time;
      min_span = item.now_ticks - cur.min_entry_time;
      arm_stage = cur.stage;
      arm_max_time = cur.max_entry_time;
      arm_min_time = cur.min_entry_time;
      case (cur.stage)
         tafm_pkg::STAGE_FREE: begin
            if (item.throttle >= cfg.throttle_high) begin
               arm_stage = tafm_pkg::STAGE_MAX;
               arm_max_time = item.now_ticks;
            end
         end
         tafm_pkg::STAGE_MAX: begin
            if (item.throttle < cfg.throttle_high) begin
               arm_stage = (max_span >= cfg.hold_ticks) ? tafm_pkg::STAGE_LEFT
                                                        : tafm_pkg::STAGE_FREE;
            end
         end
         tafm_pkg::STAGE_LEFT: begin
            if (item.throttle <= cfg.throttle_low) begin
               arm_stage = tafm_pkg::STAGE_MIN;
               arm_min_time = item.now_ticks;
            end
         end
         tafm_pkg::STAGE_MIN: begin
            if (min_span > cfg.hold_ticks) begin
               arm_stage = tafm_pkg::STAGE_UNLOCK;
            end else if (item.throttle > cfg.throttle_low) begin
               arm_stage = tafm_pkg::STAGE_FREE;
            end
         end
         default: begin
            arm_stage = cur.stage;
         end
      endcase

      case (cur.mode)
         tafm_pkg::MODE_IDLE: begin
            nxt.max_entry_time = arm_max_time;
            nxt.min_entry_time = arm_min_time;
            if (arm_stage == tafm_pkg::STAGE_UNLOCK) begin
               nxt.mode = tafm_pkg::MODE_NORMAL;
               nxt.stage = tafm_pkg::STAGE_FREE;
            end else begin
               nxt.stage = arm_stage;
            end
         end
         tafm_pkg::MODE_NORMAL: begin
            if (item.height_button) begin
               nxt.mode = tafm_pkg::MODE_HOLD;
               nxt.height = item.range_mm;
            end
            if (!nxt.link) begin
               nxt.mode = tafm_pkg::MODE_FAILED;
            end
         end
         tafm_pkg::MODE_HOLD: begin
            if (item.height_button) begin
               nxt.mode = tafm_pkg::MODE_NORMAL;
            end
            if (!nxt.link) begin
               nxt.mode = tafm_pkg::MODE_FAILED;
            end
         end
         default: begin
            if (item.resume) begin
               nxt.mode = tafm_pkg::MODE_IDLE;
            end
         end
      endcase
   end

endmodule

@@ design/throttle_arming_flight_mode_ctrl_top.sv @@
// Top level of the throttle arming and flight mode controller: input register, state,
// configuration registers and result register. Depends on tafm_pkg and tafm_step.
//
//   channel   ports                          direction   moves
//   req       req_valid req_stall req_data   in          one poll transaction
//   rsp       rsp_valid rsp_stall rsp_data   out         one result per transaction
//   csr       csr_we csr_index csr_wdata     in          register write, no read-back
//
// A transaction is captured in the input register, then evaluated and written to the
// result register and the state once the result register can advance. The single state
// update path through tafm_step gives one transaction a cycle while rsp_stall is low.
// Synchronous reset clears the state, restores the register defaults and empties both stages.
// A stalled result holds the result register, and the input register then fills and stalls req.
module throttle_arming_flight_mode_ctrl_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  tafm_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output tafm_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_we,
   input  logic [tafm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tafm_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   logic                in_valid_ff;
   logic                in_valid_in;
   tafm_pkg::req_type   in_data_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   tafm_pkg::rsp_type   out_data_ff;
   tafm_pkg::state_type state_ff;
   tafm_pkg::state_type state_in;
   tafm_pkg::cfg_type   cfg_ff;
   logic                advance;
   logic                fire;
   logic                req_take;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   tafm_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .item (in_data_ff),
      .nxt  (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.mode <= tafm_pkg::MODE_IDLE;
         state_ff.stage <= tafm_pkg::STAGE_FREE;
         state_ff.max_entry_time <= '0;
         state_ff.min_entry_time <= '0;
         state_ff.miss_count <= '0;
         state_ff.link <= 1'b0;
         state_ff.height <= '0;
         cfg_ff.throttle_high <= tafm_pkg::THROTTLE_HIGH_RESET;
         cfg_ff.throttle_low <= tafm_pkg::THROTTLE_LOW_RESET;
         cfg_ff.hold_ticks <= tafm_pkg::HOLD_TICKS_RESET;
         cfg_ff.miss_limit <= tafm_pkg::MISS_LIMIT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_we) begin
            case (csr_index)
               tafm_pkg::CSR_THROTTLE_HIGH: cfg_ff.throttle_high <= csr_wdata[15:0];
               tafm_pkg::CSR_THROTTLE_LOW:  cfg_ff.throttle_low <= csr_wdata[15:0];
               tafm_pkg::CSR_HOLD_TICKS:    cfg_ff.hold_ticks <= csr_wdata[31:0];
               tafm_pkg::CSR_MISS_LIMIT:    cfg_ff.miss_limit <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff.flight_mode <= tafm_pkg::mode_code(state_in.mode);
         out_data_ff.arm_stage <= tafm_pkg::stage_code(state_in.stage);
         out_data_ff.link_up <= state_in.link;
         out_data_ff.held_height <= state_in.height;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

`ifndef SYNTH
   // Completing the arming sequence always returns the stage to free.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.stage != tafm_pkg::STAGE_UNLOCK)
      else $error("arming stage left at unlocked");

   // The arming sequence only progresses while idle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != tafm_pkg::MODE_IDLE |-> state_ff.stage == tafm_pkg::STAGE_FREE)
      else $error("arming stage not free outside idle");

   // The link only drops on a missed-frame transaction.
   assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff.link) |->
         $past(fire) && $past(in_data_ff.link_event) == tafm_pkg::LINK_EVENT_MISS)
      else $error("link dropped without a missed frame");

   // A full input register with a free result register never stalls the input.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled while the result path was free");
`endif

endmodule

@@ tb/sv/tb_throttle_arming_flight_mode_ctrl_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for throttle_arming_flight_mode_ctrl_top: directed and random poll
// transactions are checked against an in-bench model of the link, arming and mode logic.
// Depends on tafm_pkg and the design sources of throttle_arming_flight_mode_ctrl_top.
module tb_throttle_arming_flight_mode_ctrl_top;

   localparam logic [1:0] EVENT_NONE  = 2'd0;
   localparam logic [1:0] EVENT_SPARE = 2'd3;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_stall;
   tafm_pkg::req_type                    req_data;
   logic                                 rsp_valid;
   logic                                 rsp_stall;
   tafm_pkg::rsp_type                    rsp_data;
   logic                                 csr_we;
   logic [tafm_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [tafm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   tafm_pkg::cfg_type ctl_cfg;
   logic [1:0]        exp_flight;
   logic [2:0]        exp_stage;
   logic [31:0]       exp_max_tick;
   logic [31:0]       exp_min_tick;
   logic [7:0]        exp_misses;
   logic              exp_link;
   logic [15:0]       exp_height;

   tafm_pkg::rsp_type pending_status[$];
   int                mismatches;
   bit                src_gaps;
   bit                sink_gaps;
   int                sink_burst;
   bit                link_rough;
   logic [31:0]       tick_base;
   logic [31:0]       tick_step;

   throttle_arming_flight_mode_ctrl_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic tafm_pkg::rsp_type advance_status(input tafm_pkg::req_type p);
      tafm_pkg::rsp_type r;
      logic [31:0]       elapsed;
      if (p.link_event == tafm_pkg::LINK_EVENT_GOOD) begin
         exp_link = 1'b1;
         exp_misses = 8'd0;
      end else if (p.link_event == tafm_pkg::LINK_EVENT_MISS) begin
         exp_misses = exp_misses + 8'd1;
         if (exp_misses >= ctl_cfg.miss_limit) begin
            exp_link = 1'b0;
            exp_misses = 8'd0;
         end
      end
      case (exp_flight)
         tafm_pkg::FLIGHT_IDLE: begin
            case (exp_stage)
               tafm_pkg::ARM_FREE: begin
                  if (p.throttle >= ctl_cfg.throttle_high) begin
                     exp_stage = tafm_pkg::ARM_MAX;
                     exp_max_tick = p.now_ticks;
                  end
               end
               tafm_pkg::ARM_MAX: begin
                  elapsed = p.now_ticks - exp_max_tick;
                  if (p.throttle < ctl_cfg.throttle_high)
                     exp_stage = (elapsed >= ctl_cfg.hold_ticks) ? tafm_pkg::ARM_LEFT
                                                                 : tafm_pkg::ARM_FREE;
               end
               tafm_pkg::ARM_LEFT: begin
                  if (p.throttle <= ctl_cfg.throttle_low) begin
                     exp_stage = tafm_pkg::ARM_MIN;
                     exp_min_tick = p.now_ticks;
                  end
               end
               tafm_pkg::ARM_MIN: begin
                  elapsed = p.now_ticks - exp_min_tick;
                  if (elapsed > ctl_cfg.hold_ticks)
                     exp_stage = tafm_pkg::ARM_UNLOCK;
                  else if (p.throttle > ctl_cfg.throttle_low)
                     exp_stage = tafm_pkg::ARM_FREE;
               end
               default: ;
            endcase
            if (exp_stage == tafm_pkg::ARM_UNLOCK) begin
               exp_flight = tafm_pkg::FLIGHT_NORMAL;
               exp_stage = tafm_pkg::ARM_FREE;
            end
         end
         tafm_pkg::FLIGHT_NORMAL: begin
            if (p.height_button) begin
               exp_flight = tafm_pkg::FLIGHT_HOLD;
               exp_height = p.range_mm;
            end
            if (!exp_link)
               exp_flight = tafm_pkg::FLIGHT_FAILED;
         end
         tafm_pkg::FLIGHT_HOLD: begin
            if (p.height_button)
               exp_flight = tafm_pkg::FLIGHT_NORMAL;
            if (!exp_link)
               exp_flight = tafm_pkg::FLIGHT_FAILED;
         end
         default: begin
            if (p.resume)
               exp_flight = tafm_pkg::FLIGHT_IDLE;
         end
      endcase
      r.flight_mode = exp_flight;
      r.arm_stage = exp_stage;
      r.link_up = exp_link;
      r.held_height = exp_height;
      return r;
   endfunction

   function automatic tafm_pkg::req_type make_poll(input logic [1:0] ev,
                                                   input logic [15:0] thr,
                                                   input logic btn, input logic [31:0] now,
                                                   input logic [15:0] rng, input logic res);
      tafm_pkg::req_type p;
      p.link_event = ev;
      p.throttle = thr;
      p.height_button = btn;
      p.now_ticks = now;
      p.range_mm = rng;
      p.resume = res;
      return p;
   endfunction

   // Most transactions steer the stick toward the next arming stage so that the
   // sequence completes often; the rest are unconstrained.
   function automatic tafm_pkg::req_type random_poll();
      tafm_pkg::req_type p;
      int unsigned       pick;
      logic [31:0]       elapsed;
      logic [15:0]       below_high;
      logic [15:0]       high_stick;
      logic [15:0]       low_stick;
      if ($urandom_range(0, 19) == 0)
         link_rough = !link_rough;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         p.link_event = 2'($urandom_range(0, 3));
      else if (link_rough)
         p.link_event = (pick < 85) ? tafm_pkg::LINK_EVENT_MISS : tafm_pkg::LINK_EVENT_GOOD;
      else
         p.link_event = (pick < 80) ? tafm_pkg::LINK_EVENT_GOOD : tafm_pkg::LINK_EVENT_MISS;
      if ($urandom_range(0, 49) == 0)
         tick_base = $urandom();
      else
         tick_base = tick_base + $urandom_range(0, tick_step);
      p.now_ticks = tick_base;
      high_stick = 16'($urandom_range(ctl_cfg.throttle_high, 65535));
      low_stick = 16'($urandom_range(0, ctl_cfg.throttle_low));
      below_high = (ctl_cfg.throttle_high == 16'd0) ? 16'd0 :
                   16'($urandom_range(0, ctl_cfg.throttle_high - 16'd1));
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         p.throttle = 16'($urandom_range(0, 65535));
      end else begin
         case (exp_stage)
            tafm_pkg::ARM_FREE: p.throttle = high_stick;
            tafm_pkg::ARM_MAX: begin
               elapsed = tick_base - exp_max_tick;
               p.throttle = (elapsed >= ctl_cfg.hold_ticks || pick < 35) ? below_high
                                                                         : high_stick;
            end
            default: p.throttle = low_stick;
         endcase
      end
      p.height_button = ($urandom_range(0, 4) == 0);
      p.range_mm = 16'($urandom_range(0, 65535));
      p.resume = ($urandom_range(0, 3) == 0);
      return p;
   endfunction

   task automatic send_poll(input tafm_pkg::req_type p);
      int gap;
      gap = src_gaps ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (req_stall);
      pending_status.push_back(advance_status(p));
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [tafm_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input logic [tafm_pkg::CSR_DATA_WIDTH-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         tafm_pkg::CSR_THROTTLE_HIGH: ctl_cfg.throttle_high = value[15:0];
         tafm_pkg::CSR_THROTTLE_LOW:  ctl_cfg.throttle_low = value[15:0];
         tafm_pkg::CSR_HOLD_TICKS:    ctl_cfg.hold_ticks = value;
         default:                     ctl_cfg.miss_limit = value[7:0];
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Bits above each register's width carry random values and must be dropped.
   task automatic set_config(input logic [15:0] high, input logic [15:0] low,
                             input logic [31:0] hold, input logic [7:0] limit);
      logic [31:0] noise;
      noise = $urandom();
      write_csr(tafm_pkg::CSR_THROTTLE_HIGH, {noise[31:16], high});
      write_csr(tafm_pkg::CSR_THROTTLE_LOW, {noise[15:0], low});
      write_csr(tafm_pkg::CSR_HOLD_TICKS, hold);
      write_csr(tafm_pkg::CSR_MISS_LIMIT, {noise[23:0], limit});
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_status.size() > 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
   endtask

   task automatic test_arming_defaults();
      send_poll(make_poll(tafm_pkg::LINK_EVENT_GOOD, 16'd0, 1'b1, 32'd0, 16'hFFFF, 1'b1));
      send_poll(make_poll(EVENT_SPARE, 16'hFFFF, 1'b0, 32'd0, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd899, 1'b0, 32'd999, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd900, 1'b0, 32'hFFFF_FF00, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd899, 1'b0, 32'h0000_02E8, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd101, 1'b0, 32'h0000_0300, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd100, 1'b0, 32'h0000_0400, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd0, 1'b0, 32'h0000_07E8, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd0, 1'b0, 32'h0000_07E9, 16'd0, 1'b0));
   endtask

   task automatic test_mode_changes();
      int n;
      send_poll(make_poll(tafm_pkg::LINK_EVENT_GOOD, 16'd0, 1'b1, 32'd2048, 16'hFFFF, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd0, 1'b1, 32'd2049, 16'd0, 1'b1));
      send_poll(make_poll(EVENT_NONE, 16'd0, 1'b1, 32'd2050, 16'h8001, 1'b0));
      for (n = 0; n < 9; n++)
         send_poll(make_poll(tafm_pkg::LINK_EVENT_MISS, 16'hFFFF, 1'b0, 32'd2051 + n,
                             16'd0, 1'b0));
      send_poll(make_poll(tafm_pkg::LINK_EVENT_MISS, 16'd0, 1'b1, 32'd2060, 16'h1234, 1'b0));
      send_poll(make_poll(tafm_pkg::LINK_EVENT_GOOD, 16'd0, 1'b1, 32'd2061, 16'h4321, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd0, 1'b0, 32'd2062, 16'd0, 1'b1));
   endtask

   task automatic test_config_corners();
      int n;
      drain_results();
      set_config(16'hFFFF, 16'hFFFF, 32'd0, 8'd0);
      send_poll(make_poll(tafm_pkg::LINK_EVENT_MISS, 16'hFFFF, 1'b0, 32'd10, 16'd0, 1'b0));
      send_poll(make_poll(tafm_pkg::LINK_EVENT_GOOD, 16'hFFFE, 1'b0, 32'd10, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'hFFFF, 1'b0, 32'd11, 16'd0, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'hFFFF, 1'b0, 32'd12, 16'd0, 1'b0));
      send_poll(make_poll(tafm_pkg::LINK_EVENT_MISS, 16'd0, 1'b1, 32'd13, 16'hA5C3, 1'b0));
      send_poll(make_poll(EVENT_NONE, 16'd0, 1'b0, 32'd14, 16'd0, 1'b1));
      drain_results();
      set_config(16'd0, 16'd0, 32'hFFFF_FFFF, 8'd255);
      send_poll(make_poll(tafm_pkg::LINK_EVENT_GOOD, 16'd0, 1'b0, 32'd15, 16'd0, 1'b0));
      for (n = 0; n < 5; n++)
         send_poll(make_poll(tafm_pkg::LINK_EVENT_MISS, 16'd0, 1'b0, 32'd16 + n,
                             16'd0, 1'b0));
      drain_results();
      write_csr(tafm_pkg::CSR_MISS_LIMIT, 32'd3);
      send_poll(make_poll(tafm_pkg::LINK_EVENT_MISS, 16'd0, 1'b0, 32'd21, 16'd0, 1'b0));
   endtask

   task automatic test_random_phases();
      int          phase;
      int          n;
      logic [15:0] high;
      for (phase = 0; phase < 6; phase++) begin
         drain_results();
         case (phase)
            0: set_config(tafm_pkg::THROTTLE_HIGH_RESET, tafm_pkg::THROTTLE_LOW_RESET,
                          32'd40, 8'd3);
            1: set_config(16'hFFFF, 16'hFFFF, 32'd0, 8'd1);
            2: set_config(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 8'd255);
            default: begin
               high = 16'($urandom_range(1, 65535));
               set_config(high, 16'($urandom_range(0, high)), $urandom_range(0, 60),
                          8'($urandom_range(1, 6)));
            end
         endcase
         tick_step = (ctl_cfg.hold_ticks > 32'd4000) ? 32'd500 : ctl_cfg.hold_ticks / 8 + 4;
         src_gaps = 1'($urandom_range(0, 1));
         sink_gaps = 1'($urandom_range(0, 1));
         for (n = 0; n < 80; n++)
            send_poll(random_poll());
      end
   endtask

   task automatic test_backpressure();
      int n;
      drain_results();
      src_gaps = 1'b0;
      sink_gaps = 1'b0;
      sink_burst = 150;
      for (n = 0; n < 40; n++)
         send_poll(random_poll());
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      src_gaps = 1'b1;
      sink_gaps = 1'b1;
      sink_burst = 0;
      link_rough = 1'b0;
      tick_base = 32'd0;
      tick_step = 32'd16;
      ctl_cfg.throttle_high = tafm_pkg::THROTTLE_HIGH_RESET;
      ctl_cfg.throttle_low = tafm_pkg::THROTTLE_LOW_RESET;
      ctl_cfg.hold_ticks = tafm_pkg::HOLD_TICKS_RESET;
      ctl_cfg.miss_limit = tafm_pkg::MISS_LIMIT_RESET;
      exp_flight = tafm_pkg::FLIGHT_IDLE;
      exp_stage = tafm_pkg::ARM_FREE;
      exp_max_tick = 32'd0;
      exp_min_tick = 32'd0;
      exp_misses = 8'd0;
      exp_link = 1'b0;
      exp_height = 16'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_arming_defaults();
      test_mode_changes();
      test_config_corners();
      test_random_phases();
      test_backpressure();
      drain_results();
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : result_checker
      int                wait_n;
      tafm_pkg::rsp_type want;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (sink_burst > 0) begin
            wait_n = sink_burst;
            sink_burst = 0;
         end else begin
            wait_n = sink_gaps ? $urandom_range(0, 15) : 0;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_status.size() == 0) begin
            mismatches++;
            $display("%0t: result with no transaction pending, actual %p", $time, rsp_data);
         end else begin
            want = pending_status.pop_front();
            check_field("flight_mode", 32'(want.flight_mode), 32'(rsp_data.flight_mode));
            check_field("arm_stage", 32'(want.arm_stage), 32'(rsp_data.arm_stage));
            check_field("link_up", 32'(want.link_up), 32'(rsp_data.link_up));
            check_field("held_height", 32'(want.held_height), 32'(rsp_data.held_height));
         end
         @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
